FILE: design/pbt_pkg.sv
// shared constants, command and status types, and helper functions for the tail block
`default_nettype none

package pbt_pkg;

    // block sizing
    localparam int MAX_TRIALS     = 32;
    localparam int PROB_FRAC_BITS = 16;
    localparam int DIST_FRAC_BITS = 24;

    // derived sizes
    localparam int NENT    = MAX_TRIALS + 1;
    localparam int IDX_W   = $clog2(NENT);
    localparam int STEP_W  = $clog2(MAX_TRIALS + 4);
    localparam int PROB_W  = 17;
    localparam int CNT_W   = 6;
    localparam int DIST_W  = DIST_FRAC_BITS + 1;
    localparam int PROD_W  = DIST_W + PROB_W;
    localparam int MIX_W   = PROD_W + 1;
    localparam int SUM_W   = DIST_W + $clog2(NENT);
    localparam int IN_TDATA_W  = ((PROB_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CNT_W + PROB_W + 7) / 8) * 8;

    // fixed-point constants
    localparam logic [PROB_W-1:0] ONE_P  = PROB_W'(1) << PROB_FRAC_BITS;
    localparam logic [DIST_W-1:0] ONE_D  = DIST_W'(1) << DIST_FRAC_BITS;
    localparam logic [MIX_W-1:0]  HALF_P = MIX_W'(1) << (PROB_FRAC_BITS - 1);

    // output conversion shifts
    localparam int SH_R = (DIST_FRAC_BITS > PROB_FRAC_BITS) ?
                          (DIST_FRAC_BITS - PROB_FRAC_BITS) : 0;
    localparam int SH_L = (PROB_FRAC_BITS > DIST_FRAC_BITS) ?
                          (PROB_FRAC_BITS - DIST_FRAC_BITS) : 0;
    localparam int CONV_W = SUM_W + SH_L + 1;
    localparam logic [CONV_W-1:0] CONV_RND = (SH_R > 0) ?
                          (CONV_W'(1) << ((SH_R > 0) ? (SH_R - 1) : 0)) : '0;

    // controller to datapath commands
    typedef struct packed {
        logic             accept;     // input beat taken this cycle
        logic             rd_en;      // store read
        logic [IDX_W-1:0] rd_addr;
        logic             upd_issue;  // update pass step
        logic             upd_first;  // step only primes the held entry
        logic             upd_zero;   // step feeds a zero lower neighbor
        logic [IDX_W-1:0] upd_tgt;    // entry written by this step
        logic             out_load;   // load result register
        logic [IDX_W-1:0] out_k;
        logic             out_last;
        logic             clear;      // back to point mass at zero
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic             last_trial;
        logic [IDX_W-1:0] n_trials;
    } t_status;

    // value of a store entry that has not been written since the last clear
    function automatic logic [DIST_W-1:0] rst_val(input logic [IDX_W-1:0] addr);
        rst_val = (addr == '0) ? ONE_D : '0;
    endfunction

    // exact tail sum to output format, round half up, saturate at one
    function automatic logic [PROB_W-1:0] to_out(input logic [SUM_W-1:0] acc);
        logic [CONV_W-1:0] v;
        v = ((CONV_W'(acc) + CONV_RND) >> SH_R) << SH_L;
        to_out = (v > CONV_W'(ONE_P)) ? ONE_P : v[PROB_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/pbt_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module pbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/pbt_datapath.sv
// distribution store, multiply-add pipeline, tail sums and result register
`default_nettype none

module pbt_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire pbt_pkg::t_cmd                    i_cmd,
    output pbt_pkg::t_status                      o_status,
    input  wire logic [pbt_pkg::IN_TDATA_W-1:0]   i_in_tdata,
    input  wire logic                             i_in_tlast,
    output logic      [pbt_pkg::OUT_TDATA_W-1:0]  o_out_tdata,
    output logic                                  o_out_tlast
);

    // trial registers
    logic [pbt_pkg::PROB_W-1:0] r_p;
    logic [pbt_pkg::PROB_W-1:0] r_q;
    logic                       r_last;
    logic [pbt_pkg::IDX_W-1:0]  r_trials;
    logic [pbt_pkg::PROB_W-1:0] w_in_p;

    // store and valid bits
    logic [pbt_pkg::NENT-1:0]   r_vld;
    logic [pbt_pkg::DIST_W-1:0] w_ram_q;
    logic                       w_we;
    logic [pbt_pkg::DIST_W-1:0] w_wdata;

    // read stage tags
    logic                       r_s0_v;
    logic                       r_s0_first;
    logic                       r_s0_zero;
    logic                       r_s0_vbit;
    logic [pbt_pkg::IDX_W-1:0]  r_s0_addr;
    logic [pbt_pkg::IDX_W-1:0]  r_s0_tgt;
    logic [pbt_pkg::DIST_W-1:0] w_cur;

    // multiply stage
    logic [pbt_pkg::DIST_W-1:0] r_hi;
    logic [pbt_pkg::PROB_W-1:0] w_wt;
    logic                       r_pv;
    logic [pbt_pkg::PROD_W-1:0] r_pa;
    logic [pbt_pkg::PROD_W-1:0] r_pb;
    logic [pbt_pkg::IDX_W-1:0]  r_p_tgt;

    // add, round and saturate stage
    logic [pbt_pkg::MIX_W-1:0]  w_mix;
    logic [pbt_pkg::MIX_W-1:0]  w_shift;

    // tail sums
    logic [pbt_pkg::SUM_W-1:0]  r_sum;
    logic [pbt_pkg::SUM_W-1:0]  r_prefix;
    logic [pbt_pkg::SUM_W-1:0]  w_tail;

    // result register
    logic [pbt_pkg::IDX_W-1:0]  r_out_k;
    logic [pbt_pkg::PROB_W-1:0] r_out_tail;
    logic                       r_out_last;

    // input probability clamped to one
    assign w_in_p = (i_in_tdata[pbt_pkg::PROB_W-1:0] > pbt_pkg::ONE_P) ?
                    pbt_pkg::ONE_P : i_in_tdata[pbt_pkg::PROB_W-1:0];

    // capture trial, count trials up to the limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trials <= '0;
        end else if (i_cmd.clear) begin
            r_trials <= '0;
        end else if (i_cmd.accept &&
                     r_trials != pbt_pkg::IDX_W'(pbt_pkg::MAX_TRIALS)) begin
            r_trials <= r_trials + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p    <= w_in_p;
            r_q    <= pbt_pkg::ONE_P - w_in_p;
            r_last <= i_in_tlast;
        end
    end

    assign o_status.last_trial = r_last;
    assign o_status.n_trials   = r_trials;

    // distribution store
    pbt_ram #(
        .WIDTH (pbt_pkg::DIST_W),
        .DEPTH (pbt_pkg::NENT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_p_tgt),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_ram_q)
    );

    // valid bits: unwritten entries read as the point mass at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clear) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[r_p_tgt] <= 1'b1;
        end
    end

    // read stage tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= i_cmd.upd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_first <= i_cmd.upd_first;
        r_s0_zero  <= i_cmd.upd_zero;
        r_s0_tgt   <= i_cmd.upd_tgt;
        r_s0_addr  <= i_cmd.rd_addr;
        r_s0_vbit  <= r_vld[i_cmd.rd_addr];
    end

    // effective entry value after the read
    always_comb begin
        if (r_s0_zero) begin
            w_cur = '0;
        end else if (r_s0_vbit) begin
            w_cur = w_ram_q;
        end else begin
            w_cur = pbt_pkg::rst_val(r_s0_addr);
        end
    end

    // top entry absorbs, keeping its own mass
    assign w_wt = (r_s0_tgt == pbt_pkg::IDX_W'(pbt_pkg::MAX_TRIALS)) ?
                  pbt_pkg::ONE_P : r_q;

    // multiply stage: old[k]*w and old[k-1]*p
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= r_s0_v && !r_s0_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s0_v) begin
            r_hi    <= w_cur;
            r_pa    <= r_hi * w_wt;
            r_pb    <= w_cur * r_p;
            r_p_tgt <= r_s0_tgt;
        end
    end

    // add, round half up, saturate at one, write back
    assign w_mix   = pbt_pkg::MIX_W'(r_pa) + pbt_pkg::MIX_W'(r_pb) + pbt_pkg::HALF_P;
    assign w_shift = w_mix >> pbt_pkg::PROB_FRAC_BITS;
    assign w_wdata = (w_shift > pbt_pkg::MIX_W'(pbt_pkg::ONE_D)) ?
                     pbt_pkg::ONE_D : w_shift[pbt_pkg::DIST_W-1:0];
    assign w_we    = r_pv;

    // running total of the new distribution and prefix during readout
    assign w_tail = r_sum - r_prefix;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sum    <= '0;
            r_prefix <= '0;
        end else begin
            if (w_we) begin
                r_sum <= r_sum + pbt_pkg::SUM_W'(w_wdata);
            end
            if (i_cmd.out_load) begin
                r_prefix <= r_prefix + pbt_pkg::SUM_W'(w_cur);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_k    <= i_cmd.out_k;
            r_out_tail <= pbt_pkg::to_out(w_tail);
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_out_tdata = {
        {(pbt_pkg::OUT_TDATA_W - pbt_pkg::CNT_W - pbt_pkg::PROB_W){1'b0}},
        r_out_tail,
        pbt_pkg::CNT_W'(r_out_k)
    };
    assign o_out_tlast = r_out_last;

    // a write never lands on the entry being read in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we && i_cmd.rd_en |-> r_p_tgt != i_cmd.rd_addr)
        else $error("store write and read hit the same entry");

endmodule

`default_nettype wire

FILE: design/pbt_ctrl.sv
// controller: sequences the update pass per trial and the tail readout
`default_nettype none

module pbt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire pbt_pkg::t_status i_status,
    output pbt_pkg::t_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_UPD   = 5'b00010,
        S_ORD   = 5'b00100,
        S_OWAIT = 5'b01000,
        S_OSEND = 5'b10000
    } t_state;

    localparam logic [pbt_pkg::STEP_W-1:0] STEP_ZERO =
        pbt_pkg::STEP_W'(pbt_pkg::MAX_TRIALS + 1);
    localparam logic [pbt_pkg::STEP_W-1:0] STEP_END =
        pbt_pkg::STEP_W'(pbt_pkg::MAX_TRIALS + 3);

    t_state                      r_state, n_state;
    logic [pbt_pkg::STEP_W-1:0]  r_step, n_step;
    logic [pbt_pkg::IDX_W-1:0]   r_k, n_k;
    logic                        w_accept;
    logic                        w_k_last;
    logic                        w_issue;
    logic [pbt_pkg::STEP_W-1:0]  w_rd_addr;
    logic [pbt_pkg::STEP_W-1:0]  w_tgt;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OSEND);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_k_last    = (r_k == i_status.n_trials);

    // update pass addressing: read entry MAX-step, write entry MAX-step+1
    assign w_issue   = (r_state == S_UPD) && (r_step <= STEP_ZERO);
    assign w_rd_addr = pbt_pkg::STEP_W'(pbt_pkg::MAX_TRIALS) - r_step;
    assign w_tgt     = pbt_pkg::STEP_W'(pbt_pkg::NENT) - r_step;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPD;
                    n_step  = '0;
                end
            end
            S_UPD: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_END) begin
                    n_k     = '0;
                    n_state = i_status.last_trial ? S_ORD : S_IDLE;
                end
            end
            S_ORD: begin
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                n_state = S_OSEND;
            end
            S_OSEND: begin
                if (i_out_ready) begin
                    if (w_k_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_k     <= n_k;
        end
    end

    // commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = w_accept;
        o_cmd.upd_issue = w_issue;
        o_cmd.upd_first = w_issue && (r_step == '0);
        o_cmd.upd_zero  = w_issue && (r_step == STEP_ZERO);
        o_cmd.upd_tgt   = w_tgt[pbt_pkg::IDX_W-1:0];
        o_cmd.out_k     = r_k;
        o_cmd.out_last  = w_k_last;
        o_cmd.out_load  = (r_state == S_OWAIT);
        o_cmd.clear     = (r_state == S_OSEND) && i_out_ready && w_k_last;
        if (r_state == S_ORD) begin
            o_cmd.rd_en   = 1'b1;
            o_cmd.rd_addr = r_k;
        end else begin
            o_cmd.rd_en   = w_issue && (r_step != STEP_ZERO);
            o_cmd.rd_addr = w_rd_addr[pbt_pkg::IDX_W-1:0];
        end
    end

    // input and output sides are never open together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is offered");

    // an accepted trial always starts an update pass
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready && r_step == '0)
        else $error("trial accepted without starting the update pass");

    // the final result hands back to idle with the store cleared
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && w_k_last |=> o_in_ready && i_status.n_trials == '0)
        else $error("readout end did not return to idle");

endmodule

`default_nettype wire

FILE: design/poisson_binomial_tail.sv
// top level of the success count tail block
`default_nettype none

// Takes one trial probability per input beat (Q1.16, values above one taken
// as one) and folds it into a 33-entry Q1.24 distribution of success counts
// held in a small RAM. Each trial costs an accept plus an update pass: the
// pass walks the store from the top entry down through one read port and one
// two-product multiply-add pipeline, writing each new entry back behind the
// read. After the beat flagged by tlast the block emits the tail sums
// P(count >= k) for k = 0..n, one beat per k in Q1.16 with the last one
// flagged, each held through output stalls; the store then returns to the
// point mass at zero through per-entry valid bits, so there is no clearing
// pass after reset. Trials beyond MAX_TRIALS pile into the top entry. Input
// is accepted only between trials and readouts.
module poisson_binomial_tail (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input beats
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [pbt_pkg::IN_TDATA_W-1:0]   i_s_tdata,   // [16:0] trial_prob
    input  wire logic                             i_s_tlast,   // last_trial
    // result beats
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic      [pbt_pkg::OUT_TDATA_W-1:0]  o_m_tdata,   // [5:0] count_index,
                                                               // [22:6] tail_prob
    output logic                                  o_m_tlast    // last_result
);

    pbt_pkg::t_cmd    w_cmd;
    pbt_pkg::t_status w_status;

    // sequencer
    pbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // store and arithmetic
    pbt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_tdata  (i_s_tdata),
        .i_in_tlast  (i_s_tlast),
        .o_out_tdata (o_m_tdata),
        .o_out_tlast (o_m_tlast)
    );

endmodule

`default_nettype wire
